// ----- hdl/sha1h_pkg.sv -----
`default_nettype none
package sha1h_pkg;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hc3d2e1f0;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  // byte source selected by the controller
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } byte_src_t;

  typedef struct packed {
    logic       push;       // write byte into buffer, bump fill
    byte_src_t  src;
    logic       len_inc;    // count a message byte
    logic       comp_start; // load working regs from chaining value
    logic       round;      // run one round
    logic       comp_done;  // fold working regs into chaining value
    logic       reinit;     // restart message
    logic       load_w;     // load round word from buffer
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic [6:0] round_idx;
  } dp_stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int k);
    rotl = (x << k) | (x >> (32 - k));
  endfunction

endpackage
`default_nettype wire

// ----- hdl/sha1h_ram.sv -----
`default_nettype none
module sha1h_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hdl/sha1h_datapath.sv -----
`default_nettype none
module sha1h_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sha1h_pkg::dp_cmd_t cmd,
  input  wire logic [7:0]         data_byte,
  input  wire logic [2:0]         len_sel,
  input  wire logic [2:0]         out_sel,
  output sha1h_pkg::dp_stat_t     stat,
  output logic [31:0]             cv_word
);
  import sha1h_pkg::*;

  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] len_r, len_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [31:0] cv_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] w_r [16];
  logic [31:0] wasm_r;
  logic [7:0]  wbyte;
  logic [5:0]  waddr, raddr;
  logic [7:0]  rdata;
  logic [63:0] bits;
  logic [31:0] f, k, wt, wexp, tnew;
  logic        wlast;
  logic [3:0]  widx;

  assign bits = {len_r, 3'b000};

  always_comb begin
    case (cmd.src)
      SRC_DATA: wbyte = data_byte;
      SRC_PAD:  wbyte = PAD_BYTE;
      SRC_ZERO: wbyte = 8'h00;
      SRC_LEN:  wbyte = bits[{len_sel, 3'b000} +: 8];
      default:  wbyte = 8'h00;
    endcase
  end

  assign waddr = fill_r;
  // while loading, the round counter steps through the byte addresses
  assign raddr = rnd_r[5:0];

  sha1h_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
    .clk(clk), .we(cmd.push), .waddr(waddr), .wdata(wbyte),
    .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    fill_nxt = fill_r;
    len_nxt  = len_r;
    rnd_nxt  = rnd_r;
    if (cmd.push) fill_nxt = fill_r + 6'd1;
    if (cmd.len_inc) len_nxt = len_r + 61'd1;
    if (cmd.comp_start) rnd_nxt = 7'd0;
    else if (cmd.round || cmd.load_w) rnd_nxt = rnd_r + 7'd1;
    if (cmd.reinit) begin
      fill_nxt = '0;
      len_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      len_r  <= '0;
      rnd_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      len_r  <= len_nxt;
      rnd_r  <= rnd_nxt;
    end
  end

  assign stat.fill      = fill_r;
  assign stat.round_idx = rnd_r;

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r); k = K0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r; k = K1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = K2;
    end else begin
      f = b_r ^ c_r ^ d_r; k = K3;
    end
    wexp = rotl(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0], 1);
    wt   = (rnd_r < 7'd16) ? w_r[rnd_r[3:0]] : wexp;
    tnew = rotl(a_r, 5) + f + e_r + k + wt;
  end

  // byte n leaves the RAM in the cycle after its address; a word is complete
  // when its 4th byte arrives
  assign wlast = cmd.load_w && rnd_r[1:0] == 2'd0 && rnd_r[6:2] != 5'd0;
  assign widx  = rnd_r[5:2] - 4'd1;

  always_ff @(posedge clk) begin
    if (cmd.load_w) begin
      wasm_r <= {wasm_r[23:0], rdata};
    end
    if (wlast) begin
      w_r[widx] <= {wasm_r[23:0], rdata};
    end else if (cmd.round && rnd_r >= 7'd16) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wexp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= H0; cv_r[1] <= H1; cv_r[2] <= H2; cv_r[3] <= H3; cv_r[4] <= H4;
    end else if (cmd.reinit) begin
      cv_r[0] <= H0; cv_r[1] <= H1; cv_r[2] <= H2; cv_r[3] <= H3; cv_r[4] <= H4;
    end else if (cmd.comp_done) begin
      cv_r[0] <= cv_r[0] + a_r;
      cv_r[1] <= cv_r[1] + b_r;
      cv_r[2] <= cv_r[2] + c_r;
      cv_r[3] <= cv_r[3] + d_r;
      cv_r[4] <= cv_r[4] + e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      a_r <= cv_r[0]; b_r <= cv_r[1]; c_r <= cv_r[2]; d_r <= cv_r[3]; e_r <= cv_r[4];
    end else if (cmd.round) begin
      e_r <= d_r; d_r <= c_r; c_r <= rotl(b_r, 30); b_r <= a_r; a_r <= tnew;
    end
  end

  assign cv_word = cv_r[out_sel];
endmodule
`default_nettype wire

// ----- hdl/sha1h_ctrl.sv -----
`default_nettype none
module sha1h_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_opcode,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                out_idx,
  input  wire sha1h_pkg::dp_stat_t  stat,
  output sha1h_pkg::dp_cmd_t        cmd,
  output logic [2:0]                len_sel,
  output logic                      push_last
);
  import sha1h_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PAD   = 7'b0000010,
    ST_LEN   = 7'b0000100,
    ST_LOAD  = 7'b0001000,
    ST_ROUND = 7'b0010000,
    ST_FOLD  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic       fin_r, fin_nxt;     // in finish sequence
  logic       after_r, after_nxt; // phase to return to after compression
  logic [2:0] cnt_r, cnt_nxt;
  logic [6:0] ld_r, ld_nxt;       // load step counter (64 reads plus the RAM read register)

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = state_r == ST_OUT;
  assign out_idx   = cnt_r;
  assign len_sel   = 3'd7 - cnt_r;
  assign push_last = cmd.push && stat.fill == 6'd63;

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    after_nxt = after_r;
    cnt_nxt   = cnt_r;
    ld_nxt    = ld_r;
    cmd       = '0;
    cmd.src   = SRC_DATA;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.push = 1'b1;
          if (in_opcode == OP_ADD) begin
            cmd.len_inc = 1'b1;
            cmd.src     = SRC_DATA;
          end else begin
            cmd.src = SRC_PAD;
            fin_nxt = 1'b1;
          end
          if (stat.fill == 6'd63) begin
            state_nxt = ST_LOAD;
            ld_nxt    = '0;
            cmd.comp_start = 1'b1;
          end else if (in_opcode == OP_FINISH) begin
            state_nxt = (stat.fill == LEN_OFFSET - 6'd1) ? ST_LEN : ST_PAD;
            cnt_nxt   = '0;
          end
        end
      end
      ST_PAD: begin
        cmd.push = 1'b1;
        cmd.src  = SRC_ZERO;
        if (stat.fill == 6'd63) begin
          state_nxt = ST_LOAD;
          ld_nxt    = '0;
          cmd.comp_start = 1'b1;
        end else if (stat.fill == LEN_OFFSET - 6'd1) begin
          state_nxt = ST_LEN;
          cnt_nxt   = '0;
        end
      end
      ST_LEN: begin
        cmd.push = 1'b1;
        cmd.src  = SRC_LEN;
        cnt_nxt  = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          state_nxt = ST_LOAD;
          ld_nxt    = '0;
          cmd.comp_start = 1'b1;
          after_nxt = 1'b1;
        end
      end
      ST_LOAD: begin
        cmd.load_w = 1'b1;
        ld_nxt = ld_r + 7'd1;
        if (ld_r == 7'd64) begin
          state_nxt = ST_ROUND;
          cmd.comp_start = 1'b1;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (stat.round_idx == 7'd79) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.comp_done = 1'b1;
        if (after_r) begin
          state_nxt = ST_OUT;
          cnt_nxt   = '0;
        end else if (fin_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == 3'd4) begin
            cmd.reinit = 1'b1;
            state_nxt  = ST_IDLE;
            fin_nxt    = 1'b0;
            after_nxt  = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fin_r   <= 1'b0;
      after_r <= 1'b0;
      cnt_r   <= '0;
      ld_r    <= '0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      after_r <= after_nxt;
      cnt_r   <= cnt_nxt;
      ld_r    <= ld_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND && stat.round_idx == 7'd79 |=> state_r == ST_FOLD)
    else $error("round count overrun");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r <= 3'd4)
    else $error("digest index out of range");
endmodule
`default_nettype wire

// ----- hdl/sha1_byte_stream_hasher_core.sv -----
// SHA-1 hasher fed one byte per word. An add word is taken while the core is
// idle; the 64th byte of a block starts a buffer read into the schedule
// window (one RAM port, one byte per cycle, behind the RAM read register),
// 80 rounds (one round per cycle) and a fold step, during which no new word
// is taken.
// A finish word pads, compresses one or two blocks, then presents five
// digest words, most significant first.
`default_nettype none
module sha1_byte_stream_hasher_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire sha1h_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output sha1h_pkg::out_item_t      out_data
);
  import sha1h_pkg::*;

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [2:0] len_sel, out_idx;
  logic [31:0] cv_word;
  logic       push_last;

  sha1h_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_data.opcode), .out_valid(out_valid), .out_ready(out_ready),
    .out_idx(out_idx), .stat(stat), .cmd(cmd), .len_sel(len_sel),
    .push_last(push_last)
  );

  sha1h_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .data_byte(in_data.data_byte),
    .len_sel(len_sel), .out_sel(out_idx),
    .stat(stat), .cv_word(cv_word)
  );

  assign out_data.digest_word = cv_word;
  assign out_data.word_index  = out_idx;
  assign out_data.last_word   = out_idx == 3'd4;

  assert property (@(posedge clk) disable iff (!rst_n)
    push_last |=> !in_ready)
    else $error("full block not compressed");
endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import sha1h_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  sha1_byte_stream_hasher_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #4 clk = ~clk;

  localparam int WATCHDOG_LIMIT = 20000;

  // digest model state
  logic [31:0] hash_state [5];
  logic [7:0]  msg_block [64];
  int unsigned block_fill;
  logic [60:0] msg_len;
  out_item_t   digest_queue [$];

  int  error_count = 0;
  int  words_sent = 0;
  int  digests_seen = 0;
  int  idle_pct = 19;
  bit  rx_hold = 1'b0;
  int  idle_cycles = 0;

  function automatic logic [31:0] rol32(logic [31:0] x, int k);
    return (x << k) | (x >> (32 - k));
  endfunction

  task automatic compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f;
    for (int r = 0; r < 16; r++)
      w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
    for (int r = 16; r < 80; r++)
      w[r] = rol32(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
    d = hash_state[3]; e = hash_state[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20)      f = ((b & c) | (~b & d)) + K0;
      else if (r < 40) f = (b ^ c ^ d) + K1;
      else if (r < 60) f = ((b & c) | (b & d) | (c & d)) + K2;
      else             f = (b ^ c ^ d) + K3;
      f = f + rol32(a, 5) + e + w[r];
      e = d; d = c; c = rol32(b, 30); b = a; a = f;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
    hash_state[3] += d; hash_state[4] += e;
  endtask

  task automatic push_msg_byte(logic [7:0] v);
    msg_block[block_fill] = v;
    block_fill = (block_fill + 1) % 64;
    if (block_fill == 0) compress_block();
  endtask

  task automatic restart_message();
    hash_state[0] = H0; hash_state[1] = H1; hash_state[2] = H2;
    hash_state[3] = H3; hash_state[4] = H4;
    block_fill = 0;
    msg_len = '0;
  endtask

  task automatic predict_digest(in_item_t it);
    logic [63:0] bits;
    out_item_t o;
    if (it.opcode == OP_ADD) begin
      push_msg_byte(it.data_byte);
      msg_len = msg_len + 61'd1;
      return;
    end
    bits = {msg_len, 3'b000};
    push_msg_byte(PAD_BYTE);
    while (block_fill != LEN_OFFSET) push_msg_byte(8'h00);
    for (int i = 7; i >= 0; i--) push_msg_byte(bits[i*8 +: 8]);
    for (int i = 0; i < 5; i++) begin
      o.digest_word = hash_state[i];
      o.word_index = 3'(i);
      o.last_word = (i == 4);
      digest_queue.push_back(o);
    end
    restart_message();
  endtask

  // returns at a falling edge with in_valid still high; a later idle gap or the caller drops it
  task automatic send_word(logic op, logic [7:0] b);
    in_item_t it;
    it.opcode = op;
    it.data_byte = b;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_digest(it);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(int n);
    for (int i = 0; i < n; i++) send_word(OP_ADD, 8'($urandom_range(255)));
    send_word(OP_FINISH, 8'($urandom_range(255)));
  endtask

  // checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (digest_queue.size() == 0) begin
        $error("unexpected digest word %h", out_data.digest_word);
        error_count++;
      end else begin
        out_item_t e;
        e = digest_queue.pop_front();
        if (out_data.digest_word !== e.digest_word) begin
          $error("digest_word exp %h act %h", e.digest_word, out_data.digest_word);
          error_count++;
        end
        if (out_data.word_index !== e.word_index) begin
          $error("word_index exp %0d act %0d", e.word_index, out_data.word_index);
          error_count++;
        end
        if (out_data.last_word !== e.last_word) begin
          $error("last_word exp %0d act %0d", e.last_word, out_data.last_word);
          error_count++;
        end
        if (e.last_word) digests_seen++;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rx_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(OP_FINISH, 8'hff);           // empty message
    send_message(3);
    for (int i = 0; i < 3; i++) send_word(OP_ADD, 8'h61 + 8'(i));
    send_word(OP_FINISH, 8'h00);           // "abc"
    send_word(OP_ADD, 8'h00);
    send_word(OP_ADD, 8'hff);
    send_word(OP_ADD, 8'h55);
    send_word(OP_ADD, 8'haa);
    send_word(OP_FINISH, 8'h00);
  endtask

  task automatic test_block_edges();
    send_message(55);   // pad lands just before the length field
    send_message(63);   // pad at the last offset spills to a second block
    send_message(64);   // full block then padding
  endtask

  task automatic test_backpressure();
    rx_hold = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        rx_hold = 1'b0;
      end
      begin
        send_message(2);
        send_message(1);
        send_message(0);
        in_valid <= 1'b0;
      end
    join
  endtask

  task automatic test_random();
    idle_pct = 0;
    send_message(20);
    idle_pct = 19;
    while (words_sent < 220) send_message($urandom_range(0, 8));
  endtask

  task automatic drain();
    int guard = 0;
    in_valid <= 1'b0;
    while (digest_queue.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  initial begin
    restart_message();
    for (int i = 0; i < 64; i++) msg_block[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_block_edges();
    test_backpressure();
    test_random();
    drain();
    if (digest_queue.size() != 0) error_count++;
    $display("Sent %0d words over %0d digests, incl. empty, pad-spill and stall cases.",
             words_sent, digests_seen);
    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
hdl/sha1h_pkg.sv
hdl/sha1h_ram.sv
hdl/sha1h_datapath.sv
hdl/sha1h_ctrl.sv
hdl/sha1_byte_stream_hasher_core.sv
dv/tb_top.sv
